// ===== rtl/core/ptm_pkg.sv =====
`default_nettype none

package ptm_pkg;

    // Default geometry of the frame store.
    localparam int NUM_FRAMES_DEF    = 64;
    localparam int KERNEL_FRAMES_DEF = 16;

    // Page layout: 4 KiB pages, 1024 entries of 32 bits per frame.
    localparam int PAGE_BYTES      = 4096;
    localparam int PAGE_SHIFT      = 12;
    localparam int IDX_W           = 10;
    localparam int WORDS_PER_FRAME = 1024;
    localparam int ENTRY_W         = 32;
    localparam int FRAME_NUM_W     = ENTRY_W - PAGE_SHIFT;
    localparam int FLAGS_W         = 12;
    localparam int DIR_FRAME_W     = 6;

    // Entry bit fields.
    localparam logic [ENTRY_W-1:0] PRESENT_BIT = 32'h0000_0001;
    localparam logic [ENTRY_W-1:0] FRAME_MASK  = 32'hFFFF_F000;

    // Operation codes of an input item.
    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_MAP   = 2'd1,
        OP_ALIAS = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

endpackage

`default_nettype wire

// ===== rtl/core/ptm_ram.sv =====
`default_nettype none

module ptm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port: one write or one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/page_table_mapper_with_frame_alloc_core.sv =====
`default_nettype none

// Two-level page table mapper with a bump frame allocator.
// Input channel: in_valid / in_stall carry one item (opcode, dir_frame,
// virt_addr, alias_addr, entry_flags). Output channel: out_valid / out_stall
// carry exactly one result item per input item, in order.
// All page tables live in one single-port RAM of NUM_FRAMES * 1024 words
// with a registered read; every directory or table access is a serial
// read or write of that port. Allocate and no operation go straight to the
// completion state; map reads and checks or fills the directory entry, then
// the table entry; alias reads the source entries, checks or fills the target
// directory entry, then writes the aliased entry. Items are taken only in idle.
// Frames are never freed, so frame usage is a next-free pointer that starts
// at KERNEL_FRAMES, capped at NUM_FRAMES.
// After reset the block runs a clearing pass that writes zero to every RAM
// word and holds in_stall high meanwhile.
// The output register holds a finished result while out_stall is high; a
// new item may be accepted in the meantime, but its result waits until the
// register is free.
module page_table_mapper_with_frame_alloc_core #(
    parameter int NUM_FRAMES    = ptm_pkg::NUM_FRAMES_DEF,
    parameter int KERNEL_FRAMES = ptm_pkg::KERNEL_FRAMES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [5:0]  dir_frame,
    input  wire logic [31:0] virt_addr,
    input  wire logic [31:0] alias_addr,
    input  wire logic [11:0] entry_flags,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      frame_addr,
    output logic [31:0]      dir_entry,
    output logic [31:0]      table_entry,
    output logic             alloc_failed,
    output logic             out_of_range
);

    localparam int FW     = $clog2(NUM_FRAMES);
    localparam int IW     = ptm_pkg::IDX_W;
    localparam int AW     = FW + IW;
    localparam int DEPTH  = NUM_FRAMES * ptm_pkg::WORDS_PER_FRAME;
    localparam int NF_W   = $clog2(NUM_FRAMES + 1);
    localparam int KSTART = (KERNEL_FRAMES < NUM_FRAMES) ? KERNEL_FRAMES : NUM_FRAMES;
    localparam int EW     = ptm_pkg::ENTRY_W;
    localparam int FNW    = ptm_pkg::FRAME_NUM_W;
    localparam int PS     = ptm_pkg::PAGE_SHIFT;

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_A_DRD  = 11'b000_0000_0100,
        S_A_TRD  = 11'b000_0000_1000,
        S_A_PHYS = 11'b000_0001_0000,
        S_DRD    = 11'b000_0010_0000,
        S_DCHK   = 11'b000_0100_0000,
        S_TRD    = 11'b000_1000_0000,
        S_TCHK   = 11'b001_0000_0000,
        S_AWR    = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } state_t;

    // Control registers.
    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [NF_W-1:0] nf_reg, nf_next;
    logic            out_valid_reg, out_valid_next;
    logic            rd_oor_reg, rd_oor_next;

    // Item registers.
    ptm_pkg::opcode_t op_reg, op_next;
    logic [5:0]      dframe_reg, dframe_next;
    logic [31:0]     va_reg, va_next;
    logic [31:0]     tgt_reg, tgt_next;
    logic [11:0]     flags_reg, flags_next;
    logic [31:0]     faddr_reg, faddr_next;
    logic [31:0]     de_reg, de_next;
    logic [31:0]     te_reg, te_next;
    logic [31:0]     phys_reg, phys_next;
    logic            fail_reg, fail_next;
    logic            oor_reg, oor_next;

    // Output register.
    logic [31:0]     out_faddr_reg, out_faddr_next;
    logic [31:0]     out_de_reg, out_de_next;
    logic [31:0]     out_te_reg, out_te_next;
    logic            out_fail_reg, out_fail_next;
    logic            out_oor_reg, out_oor_next;

    // Memory port.
    logic            ram_en, ram_we;
    logic [AW-1:0]   ram_addr;
    logic [EW-1:0]   ram_wdata, ram_rdata, rd_data;

    // Access request from the sequencer.
    logic            acc_rd, acc_wr, acc_ok;
    logic [FNW-1:0]  acc_frame;
    logic [IW-1:0]   acc_idx;
    logic [EW-1:0]   acc_wdata;

    // Allocator.
    logic            alloc_take, alloc_ok;
    logic [31:0]     alloc_addr;

    ptm_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // A read of a frame beyond the store returns zero.
    assign rd_data = rd_oor_reg ? '0 : ram_rdata;

    // The next free frame is the lowest free one, since frames are never released.
    assign alloc_ok   = nf_reg < NF_W'(NUM_FRAMES);
    assign alloc_addr = alloc_ok ? (32'(nf_reg) << PS) : 32'd0;

    // Sequencer: at most one memory access per cycle.
    always_comb
    begin
        logic [31:0] new_entry;

        new_entry      = '0;
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        rd_oor_next    = rd_oor_reg;
        op_next        = op_reg;
        dframe_next    = dframe_reg;
        va_next        = va_reg;
        tgt_next       = tgt_reg;
        flags_next     = flags_reg;
        faddr_next     = faddr_reg;
        de_next        = de_reg;
        te_next        = te_reg;
        phys_next      = phys_reg;
        fail_next      = fail_reg;
        oor_next       = oor_reg;
        out_faddr_next = out_faddr_reg;
        out_de_next    = out_de_reg;
        out_te_next    = out_te_reg;
        out_fail_next  = out_fail_reg;
        out_oor_next   = out_oor_reg;
        acc_rd         = 1'b0;
        acc_wr         = 1'b0;
        acc_frame      = '0;
        acc_idx        = '0;
        acc_wdata      = '0;
        alloc_take     = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                acc_wr       = 1'b1;
                acc_frame    = FNW'(clr_cnt_reg[AW-1:IW]);
                acc_idx      = clr_cnt_reg[IW-1:0];
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = ptm_pkg::opcode_t'(opcode);
                    dframe_next = dir_frame;
                    va_next     = virt_addr;
                    flags_next  = entry_flags;
                    faddr_next  = '0;
                    de_next     = '0;
                    te_next     = '0;
                    fail_next   = 1'b0;
                    oor_next    = 1'b0;
                    unique case (ptm_pkg::opcode_t'(opcode))
                        ptm_pkg::OP_ALLOC:
                        begin
                            alloc_take = 1'b1;
                            faddr_next = alloc_addr;
                            fail_next  = !alloc_ok;
                            state_next = S_DONE;
                        end
                        ptm_pkg::OP_MAP:
                        begin
                            tgt_next   = virt_addr;
                            state_next = S_DRD;
                        end
                        ptm_pkg::OP_ALIAS:
                        begin
                            tgt_next   = alias_addr;
                            state_next = S_A_DRD;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_A_DRD:
            begin
                // Source directory entry.
                acc_rd     = 1'b1;
                acc_frame  = FNW'(dframe_reg);
                acc_idx    = va_reg[31:22];
                state_next = S_A_TRD;
            end
            S_A_TRD:
            begin
                // Source table entry, present bit not checked.
                acc_rd     = 1'b1;
                acc_frame  = rd_data[31:PS];
                acc_idx    = va_reg[21:12];
                state_next = S_A_PHYS;
            end
            S_A_PHYS:
            begin
                // Keep the source frame and read the target directory entry.
                phys_next  = rd_data & ptm_pkg::FRAME_MASK;
                acc_rd     = 1'b1;
                acc_frame  = FNW'(dframe_reg);
                acc_idx    = tgt_reg[31:22];
                state_next = S_DCHK;
            end
            S_DRD:
            begin
                acc_rd     = 1'b1;
                acc_frame  = FNW'(dframe_reg);
                acc_idx    = tgt_reg[31:22];
                state_next = S_DCHK;
            end
            S_DCHK:
            begin
                // Fill a directory entry that is not present.
                if ((rd_data & ptm_pkg::PRESENT_BIT) != '0)
                begin
                    de_next = rd_data;
                end
                else
                begin
                    alloc_take = 1'b1;
                    new_entry  = alloc_addr | 32'(flags_reg);
                    de_next    = new_entry;
                    if (!alloc_ok)
                    begin
                        fail_next = 1'b1;
                    end
                    acc_wr    = 1'b1;
                    acc_frame = FNW'(dframe_reg);
                    acc_idx   = tgt_reg[31:22];
                    acc_wdata = new_entry;
                end
                state_next = (op_reg == ptm_pkg::OP_ALIAS) ? S_AWR : S_TRD;
            end
            S_TRD:
            begin
                acc_rd     = 1'b1;
                acc_frame  = de_reg[31:PS];
                acc_idx    = tgt_reg[21:12];
                state_next = S_TCHK;
            end
            S_TCHK:
            begin
                // Fill a table entry that is not present.
                if ((rd_data & ptm_pkg::PRESENT_BIT) != '0)
                begin
                    te_next = rd_data;
                end
                else
                begin
                    alloc_take = 1'b1;
                    new_entry  = alloc_addr | 32'(flags_reg);
                    te_next    = new_entry;
                    if (!alloc_ok)
                    begin
                        fail_next = 1'b1;
                    end
                    acc_wr    = 1'b1;
                    acc_frame = de_reg[31:PS];
                    acc_idx   = tgt_reg[21:12];
                    acc_wdata = new_entry;
                end
                state_next = S_DONE;
            end
            S_AWR:
            begin
                // Write the aliased entry into the target table.
                new_entry  = phys_reg | 32'(flags_reg);
                te_next    = new_entry;
                acc_wr     = 1'b1;
                acc_frame  = de_reg[31:PS];
                acc_idx    = tgt_reg[21:12];
                acc_wdata  = new_entry;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_faddr_next = faddr_reg;
                    out_de_next    = de_reg;
                    out_te_next    = te_reg;
                    out_fail_next  = fail_reg;
                    out_oor_next   = oor_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Range check on the accessed frame; out-of-range writes are dropped.
        acc_ok    = acc_frame < FNW'(NUM_FRAMES);
        ram_en    = (acc_rd || acc_wr) && acc_ok;
        ram_we    = acc_wr && acc_ok;
        ram_addr  = {acc_frame[FW-1:0], acc_idx};
        ram_wdata = acc_wdata;
        if ((acc_rd || acc_wr) && !acc_ok)
        begin
            oor_next = 1'b1;
        end
        if (acc_rd)
        begin
            rd_oor_next = !acc_ok;
        end

        // Advance the next-free pointer on a successful allocation.
        nf_next = (alloc_take && alloc_ok) ? nf_reg + 1'b1 : nf_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            nf_reg        <= NF_W'(KSTART);
            out_valid_reg <= 1'b0;
            rd_oor_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            nf_reg        <= nf_next;
            out_valid_reg <= out_valid_next;
            rd_oor_reg    <= rd_oor_next;
        end
    end

    // Item and result payload.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        dframe_reg    <= dframe_next;
        va_reg        <= va_next;
        tgt_reg       <= tgt_next;
        flags_reg     <= flags_next;
        faddr_reg     <= faddr_next;
        de_reg        <= de_next;
        te_reg        <= te_next;
        phys_reg      <= phys_next;
        fail_reg      <= fail_next;
        oor_reg       <= oor_next;
        out_faddr_reg <= out_faddr_next;
        out_de_reg    <= out_de_next;
        out_te_reg    <= out_te_next;
        out_fail_reg  <= out_fail_next;
        out_oor_reg   <= out_oor_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign frame_addr   = out_faddr_reg;
    assign dir_entry    = out_de_reg;
    assign table_entry  = out_te_reg;
    assign alloc_failed = out_fail_reg;
    assign out_of_range = out_oor_reg;

    // The next-free pointer never runs past the frame count.
    a_nf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nf_reg <= NF_W'(NUM_FRAMES))
        else $error("next-free frame pointer beyond frame count");

    // A new result appears only from the completion state.
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion state");

    // A failed allocation in a result means the frames were exhausted.
    a_fail_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_fail_reg) |-> (nf_reg == NF_W'(NUM_FRAMES)))
        else $error("allocation failure reported with free frames left");

    // An accepted item always leaves the idle state.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start work");

endmodule

`default_nettype wire
